@@ design/first_fit_max_tree_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// first_fit_max_tree_allocator assertion macros
// Concurrent checks clocked on i_clk, muted while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_MAX_TREE_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_MAX_TREE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FFMT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FFMT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ffmt_pkg.sv @@
// ----------------------------------------------------------------------------
// ffmt_pkg
// Widths, codes and state type shared by the first-fit max-tree allocator.
// ----------------------------------------------------------------------------
package ffmt_pkg;

    localparam int MODE_W     = 2;
    localparam int BIN_W      = 10;
    localparam int AMT_W      = 32;
    localparam int VAL_W      = AMT_W + 1;   // signed node value, -1 = consumed
    localparam int GRANT_W    = 11;
    localparam int LEAVES_DEF = 1024;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_LOAD    = 2'd1,
        MODE_REQUEST = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_ROOT,
        ST_DOWN,
        ST_UP,
        ST_FINISH
    } t_state;

endpackage

@@ design/ffmt_if.sv @@
// ----------------------------------------------------------------------------
// ffmt_if
// Valid/ready channels for allocator commands and results.
// ----------------------------------------------------------------------------
interface ffmt_req_if;
    import ffmt_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [BIN_W-1:0]   bin_index;
    logic [AMT_W-1:0]   amount;

    modport source (output valid, mode, bin_index, amount, input ready);
    modport sink   (input valid, mode, bin_index, amount, output ready);
endinterface

interface ffmt_rsp_if;
    import ffmt_pkg::*;

    logic               valid;
    logic               ready;
    logic               granted;
    logic [BIN_W-1:0]   chosen_bin;
    logic [GRANT_W-1:0] grant_count;

    modport source (output valid, granted, chosen_bin, grant_count, input ready);
    modport sink   (input valid, granted, chosen_bin, grant_count, output ready);
endinterface

@@ design/ffmt_tree_ram.sv @@
// ----------------------------------------------------------------------------
// ffmt_tree_ram
// Node store of the max-tree: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffmt_tree_ram #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 33
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [1 << ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/ffmt_cmp.sv @@
// ----------------------------------------------------------------------------
// ffmt_cmp
// Shared signed compare: a >= b, and the larger of the two.
// ----------------------------------------------------------------------------
module ffmt_cmp (
    input  logic signed [ffmt_pkg::VAL_W-1:0] i_a,
    input  logic signed [ffmt_pkg::VAL_W-1:0] i_b,
    output logic                              o_ge,
    output logic signed [ffmt_pkg::VAL_W-1:0] o_max
);
    import ffmt_pkg::*;

    assign o_ge  = (i_a >= i_b);
    assign o_max = o_ge ? i_a : i_b;

endmodule

@@ design/first_fit_max_tree_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_max_tree_allocator
// First-fit bin allocator over a binary max-tree held in one RAM.
// ----------------------------------------------------------------------------
// One command beat in, exactly one result beat out (except the power-up
// sweep, which emits nothing). A load refreshes its leaf's path to the root;
// a request that fits reads the root, descends level by level to a leaf,
// consumes it and refreshes the path; one that does not fit ends at the root
// read. With SPAN the next power of two at or above LEAVES, after reset the
// block sweeps all 2*SPAN-1 nodes, one a cycle, before it accepts a beat.
// The single read and write port of the node RAM makes every tree level cost
// one RAM access, and one comparator serves both the descent (child max >=
// demand) and the refresh (max of two children). A finished result sits in
// an output register while the next command is taken.
// ----------------------------------------------------------------------------
module first_fit_max_tree_allocator #(
    parameter int LEAVES = ffmt_pkg::LEAVES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffmt_req_if.sink   i_req,
    ffmt_rsp_if.source o_rsp
);
    import ffmt_pkg::*;

    localparam int LOG2SPAN = $clog2(LEAVES);
    localparam int SPAN     = 1 << LOG2SPAN;
    localparam int NODE_W   = LOG2SPAN + 1;   // node index 1 .. 2*SPAN-1
    localparam int THR_W    = LOG2SPAN + 2;   // padding threshold up to 2*SPAN

    localparam logic [NODE_W-1:0] NODE_ROOT = NODE_W'(1);
    localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(2 * SPAN - 1);
    localparam logic [NODE_W-1:0] NODE_SPAN = NODE_W'(SPAN);
    localparam logic [THR_W-1:0]  THR_INIT  = THR_W'(SPAN + LEAVES);

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [NODE_W-1:0]        r_node,  n_node;    // walk node / sweep address
    logic [NODE_W-1:0]        r_base,  n_base;    // first node of sweep level
    logic [THR_W-1:0]         r_thr,   n_thr;     // first padding node of level
    logic                     r_emit,  n_emit;    // sweep came from a clear
    logic signed [VAL_W-1:0]  r_cur,   n_cur;     // value of r_node on the way up
    logic [AMT_W-1:0]         r_amount, n_amount;
    logic [GRANT_W-1:0]       r_grants, n_grants;
    logic                     r_granted, n_granted;
    logic [BIN_W-1:0]         r_chosen, n_chosen;

    logic                     r_out_valid, n_out_valid;
    logic                     r_o_granted;
    logic [BIN_W-1:0]         r_o_chosen;
    logic [GRANT_W-1:0]       r_o_count;

    // ------------------------------------------------------------------
    // RAM and shared comparator
    // ------------------------------------------------------------------
    logic                    ram_we;
    logic [NODE_W-1:0]       ram_waddr;
    logic [VAL_W-1:0]        ram_wdata;
    logic [NODE_W-1:0]       ram_raddr;
    logic [VAL_W-1:0]        ram_rdata;
    logic signed [VAL_W-1:0] rdata_s;

    logic signed [VAL_W-1:0] cmp_a, cmp_b, cmp_max;
    logic                    cmp_ge;

    ffmt_tree_ram #(
        .ADDR_W (NODE_W),
        .DATA_W (VAL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rdata_s = $signed(ram_rdata);

    ffmt_cmp u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_ge  (cmp_ge),
        .o_max (cmp_max)
    );

    // refresh compares the carried value with the sibling; descent compares
    // the read node with the demand
    assign cmp_a = (r_state == ST_UP) ? r_cur   : rdata_s;
    assign cmp_b = (r_state == ST_UP) ? rdata_s : $signed({1'b0, r_amount});

    // ------------------------------------------------------------------
    // decode
    // ------------------------------------------------------------------
    logic              in_fire;
    logic              out_load;
    logic              load_ok;
    logic [NODE_W-1:0] load_leaf;
    logic [NODE_W-1:0] child;
    logic [NODE_W-1:0] parent;
    logic              sweep_pad;

    assign i_req.ready = (r_state == ST_IDLE);
    assign in_fire     = i_req.valid && i_req.ready;
    assign out_load    = (r_state == ST_FINISH) && (!r_out_valid || o_rsp.ready);

    assign load_ok   = (32'(i_req.bin_index) < 32'(LEAVES));
    assign load_leaf = NODE_W'(SPAN + 32'(i_req.bin_index));
    // left child when it covers the demand
    assign child     = {r_node[LOG2SPAN-1:0], !cmp_ge};
    assign parent    = r_node >> 1;
    assign sweep_pad = ({1'b0, r_node} >= r_thr);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_SWEEP: begin
                if (r_node == NODE_ROOT) begin
                    n_state = r_emit ? ST_FINISH : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    case (t_mode'(i_req.mode))
                        MODE_CLEAR:   n_state = ST_SWEEP;
                        MODE_LOAD:    n_state = load_ok ? ST_UP : ST_FINISH;
                        MODE_REQUEST: n_state = ST_ROOT;
                        default:      n_state = ST_FINISH;
                    endcase
                end
            end
            ST_ROOT: begin
                n_state = cmp_ge ? ST_DOWN : ST_FINISH;
            end
            ST_DOWN: begin
                if (child[LOG2SPAN]) begin
                    n_state = ST_UP;
                end
            end
            ST_UP: begin
                if (parent == NODE_ROOT) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath and RAM control
    // ------------------------------------------------------------------
    always_comb begin
        n_node    = r_node;
        n_base    = r_base;
        n_thr     = r_thr;
        n_emit    = r_emit;
        n_cur     = r_cur;
        n_amount  = r_amount;
        n_grants  = r_grants;
        n_granted = r_granted;
        n_chosen  = r_chosen;
        ram_we    = 1'b0;
        ram_waddr = r_node;
        ram_wdata = '0;
        ram_raddr = NODE_ROOT;   // idle keeps the root ready for a request

        case (r_state)
            ST_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = r_node;
                ram_wdata = sweep_pad ? '1 : '0;
                n_node    = r_node - 1'b1;
                if (r_node == r_base) begin
                    n_base = r_base >> 1;
                    n_thr  = THR_W'(({1'b0, r_thr} + 1'b1) >> 1);
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    n_granted = 1'b0;
                    n_chosen  = '0;
                    n_amount  = i_req.amount;
                    case (t_mode'(i_req.mode))
                        MODE_CLEAR: begin
                            n_node   = NODE_LAST;
                            n_base   = NODE_SPAN;
                            n_thr    = THR_INIT;
                            n_emit   = 1'b1;
                            n_grants = '0;
                        end
                        MODE_LOAD: begin
                            if (load_ok) begin
                                ram_we    = 1'b1;
                                ram_waddr = load_leaf;
                                ram_wdata = {1'b0, i_req.amount};
                                n_cur     = $signed({1'b0, i_req.amount});
                                n_node    = load_leaf;
                                ram_raddr = load_leaf ^ NODE_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ROOT: begin
                n_node    = NODE_ROOT;
                ram_raddr = NODE_W'(2);
            end
            ST_DOWN: begin
                n_node = child;
                if (child[LOG2SPAN]) begin
                    // leaf reached: consume it and start the refresh
                    ram_we    = 1'b1;
                    ram_waddr = child;
                    ram_wdata = '1;
                    n_cur     = '1;
                    ram_raddr = child ^ NODE_W'(1);
                    n_granted = 1'b1;
                    n_chosen  = BIN_W'(child[LOG2SPAN-1:0]);
                    if (r_grants != '1) begin
                        n_grants = r_grants + 1'b1;
                    end
                end else begin
                    ram_raddr = {child[LOG2SPAN-1:0], 1'b0};
                end
            end
            ST_UP: begin
                ram_we    = 1'b1;
                ram_waddr = parent;
                ram_wdata = cmp_max;
                n_cur     = cmp_max;
                n_node    = parent;
                ram_raddr = parent ^ NODE_W'(1);
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.granted     = r_o_granted;
    assign o_rsp.chosen_bin  = r_o_chosen;
    assign o_rsp.grant_count = r_o_count;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_node      <= NODE_LAST;
            r_base      <= NODE_SPAN;
            r_thr       <= THR_INIT;
            r_emit      <= 1'b0;
            r_grants    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_node      <= n_node;
            r_base      <= n_base;
            r_thr       <= n_thr;
            r_emit      <= n_emit;
            r_grants    <= n_grants;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_amount  <= n_amount;
        r_granted <= n_granted;
        r_chosen  <= n_chosen;
        if (out_load) begin
            r_o_granted <= r_granted;
            r_o_chosen  <= r_chosen;
            r_o_count   <= r_grants;
        end
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
`include "first_fit_max_tree_allocator_assert.svh"

    `FFMT_ASSERT_NOW(a_grant_counted, o_rsp.valid && o_rsp.granted, o_rsp.grant_count != '0, "granted beat with zero grant count")
    `FFMT_ASSERT_NOW(a_miss_bin_zero, o_rsp.valid && !o_rsp.granted, o_rsp.chosen_bin == '0, "refused beat carries a bin")
    `FFMT_ASSERT_NOW(a_down_inner, r_state == ST_DOWN, (r_node != '0) && !r_node[LOG2SPAN], "descent left the inner nodes")
    `FFMT_ASSERT_NOW(a_sweep_levels, (r_state == ST_SWEEP) && (r_node == NODE_ROOT), r_base == NODE_ROOT, "sweep level tracking slipped")
    `FFMT_ASSERT_NXT(a_clear_reports, (r_state == ST_SWEEP) && (r_node == NODE_ROOT) && r_emit, r_state == ST_FINISH, "clear sweep ended without a result")

endmodule

@@ verif/tb_first_fit_max_tree_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_first_fit_max_tree_allocator
// Self-checking bench: a directed opener, then about 1500 random clear,
// load, request and unused-mode beats with random idles on both channels.
// Each accepted command runs through a local max-tree predictor; each result
// beat is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_first_fit_max_tree_allocator;
    timeunit 1ns;
    timeprecision 1ps;
    import ffmt_pkg::*;

    localparam int LEAVES        = LEAVES_DEF;
    localparam int SPAN          = 1 << $clog2(LEAVES);
    localparam int NODES         = 2 * SPAN;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic signed [VAL_W-1:0] BIN_SPENT = -1;
    localparam int IDLE_PCT      = 27;
    // beats sent in this window see no idling on either channel
    localparam int CALM_FIRST    = 600;
    localparam int CALM_LAST     = 900;
    localparam int RANDOM_BEATS  = 1530;
    localparam int DRAIN_EVERY   = 400;
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [BIN_W-1:0]   bin;
        logic [AMT_W-1:0]   amount;
        bit                 drain;   // hold this beat until all results are in
    } t_alloc_cmd;

    typedef struct packed {
        logic               granted;
        logic [BIN_W-1:0]   chosen;
        logic [GRANT_W-1:0] grant_count;
    } t_alloc_rsp;

    logic i_clk;
    logic i_rst_n;

    ffmt_req_if req_ch ();
    ffmt_rsp_if rsp_ch ();

    first_fit_max_tree_allocator #(
        .LEAVES (LEAVES)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // ------------------------------------------------------------------------
    // Predictor state: node 1 is the root, leaves sit at SPAN..NODES-1.
    // Values are 33-bit signed so a spent bin (-1) loses to any demand.
    // ------------------------------------------------------------------------
    logic signed [VAL_W-1:0] cap_tree [1:NODES-1];
    logic [GRANT_W-1:0]      grant_tally;

    t_alloc_cmd  cmd_backlog[$];
    t_alloc_rsp  predicted_rsps[$];
    bit          cmd_fired   = 1'b0;
    int unsigned beats_sent  = 0;
    int unsigned mismatches  = 0;

    // recompute the maxima from a leaf's parent up to the root
    function automatic void rebuild_path(int unsigned leaf);
        int unsigned node;
        node = (SPAN + leaf) >> 1;
        while (node >= 1) begin
            cap_tree[node] = (cap_tree[2*node] > cap_tree[2*node+1]) ?
                             cap_tree[2*node] : cap_tree[2*node+1];
            node = node >> 1;
        end
    endfunction

    // real bins go to 0, padding leaves to spent, inner nodes rebuilt bottom-up
    function automatic void wipe_tree();
        for (int n = NODES - 1; n >= 1; n--) begin
            if (n >= SPAN) begin
                cap_tree[n] = (n - SPAN >= LEAVES) ? BIN_SPENT : '0;
            end else begin
                cap_tree[n] = (cap_tree[2*n] > cap_tree[2*n+1]) ?
                              cap_tree[2*n] : cap_tree[2*n+1];
            end
        end
        grant_tally = '0;
    endfunction

    // apply one accepted command to the predictor, return the result it owes
    function automatic t_alloc_rsp apply_cmd(t_alloc_cmd cmd);
        t_alloc_rsp              rsp;
        logic signed [VAL_W-1:0] demand;
        int unsigned             node;
        rsp    = '0;
        demand = {1'b0, cmd.amount};
        case (cmd.mode)
            MODE_CLEAR: begin
                wipe_tree();
            end
            MODE_LOAD: begin
                if (cmd.bin < LEAVES) begin
                    cap_tree[SPAN + cmd.bin] = demand;
                    rebuild_path(cmd.bin);
                end
            end
            MODE_REQUEST: begin
                // descend leftmost-first; root max decides whether anything fits
                if (cap_tree[1] >= demand) begin
                    node = 1;
                    while (node < SPAN) begin
                        if (cap_tree[2*node] >= demand) begin
                            node = 2 * node;
                        end else begin
                            node = 2 * node + 1;
                        end
                    end
                    cap_tree[node] = BIN_SPENT;
                    rebuild_path(node - SPAN);
                    rsp.granted = 1'b1;
                    rsp.chosen  = BIN_W'(node - SPAN);
                    if (grant_tally != '1) begin
                        grant_tally = grant_tally + 1'b1;
                    end
                end
            end
            default: begin
                // unused mode: no state change
            end
        endcase
        rsp.grant_count = grant_tally;
        return rsp;
    endfunction

    task automatic queue_cmd(logic [MODE_W-1:0] mode, logic [BIN_W-1:0] bin,
                             logic [AMT_W-1:0] amount, bit drain = 1'b0);
        t_alloc_cmd c;
        c.mode   = mode;
        c.bin    = bin;
        c.amount = amount;
        c.drain  = drain;
        cmd_backlog.push_back(c);
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Driver: command beats and result-side ready change on the falling edge.
    // A beat on the bus is held until the monitor reports it taken.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_alloc_cmd nxt;
        bit         calm;
        calm = (beats_sent >= CALM_FIRST) && (beats_sent < CALM_LAST);
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            if (!req_ch.valid || cmd_fired) begin
                cmd_fired = 1'b0;
                // a drain-marked beat waits for every outstanding result
                if (cmd_backlog.size() != 0 &&
                    !(cmd_backlog[0].drain && predicted_rsps.size() != 0) &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    nxt = cmd_backlog.pop_front();
                    req_ch.mode      <= nxt.mode;
                    req_ch.bin_index <= nxt.bin;
                    req_ch.amount    <= nxt.amount;
                    req_ch.valid     <= 1'b1;
                    beats_sent++;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: on the rising edge, check a taken result beat first, then
    // predict for a taken command beat (its result cannot come the same edge).
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_alloc_rsp seen;
        t_alloc_rsp want;
        t_alloc_cmd taken;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            seen.granted     = rsp_ch.granted;
            seen.chosen      = rsp_ch.chosen_bin;
            seen.grant_count = rsp_ch.grant_count;
            if (predicted_rsps.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: unexpected result granted=%0b bin=%0d count=%0d",
                             $time, seen.granted, seen.chosen, seen.grant_count);
                end
            end else begin
                want = predicted_rsps.pop_front();
                if (seen.granted !== want.granted || seen.chosen !== want.chosen ||
                    seen.grant_count !== want.grant_count) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: result mismatch exp granted=%0b bin=%0d count=%0d",
                                 $time, want.granted, want.chosen, want.grant_count);
                        $display("%0t:                 got granted=%0b bin=%0d count=%0d",
                                 $time, seen.granted, seen.chosen, seen.grant_count);
                    end
                end
            end
        end
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            taken.mode   = req_ch.mode;
            taken.bin    = req_ch.bin_index;
            taken.amount = req_ch.amount;
            taken.drain  = 1'b0;
            predicted_rsps.push_back(apply_cmd(taken));
            cmd_fired = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        logic [AMT_W-1:0] cap_memory[$];
        logic [AMT_W-1:0] amt;
        logic [BIN_W-1:0] bin;
        int unsigned      pick;
        int unsigned      kind;

        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.mode      = MODE_CLEAR;
        req_ch.bin_index = '0;
        req_ch.amount    = '0;
        rsp_ch.ready     = 1'b0;
        wipe_tree();

        // Directed opener. Bin index is junk in request/clear beats on purpose.
        queue_cmd(MODE_REQUEST, 10'h3FF, 32'd0);           // zero demand: empty bin 0 fits
        queue_cmd(MODE_REQUEST, 10'h000, 32'd1);           // no fit, all else empty
        queue_cmd(MODE_LOAD,    10'h3FF, 32'hFFFF_FFFF);   // last bin, full capacity
        queue_cmd(MODE_LOAD,    10'd5,   32'd100);
        queue_cmd(MODE_REQUEST, 10'd0,   32'd50);          // bin 5
        queue_cmd(MODE_REQUEST, 10'd0,   32'd100);         // bin 5 spent, so last bin
        queue_cmd(MODE_REQUEST, 10'h2AA, 32'hFFFF_FFFF);   // max demand, nothing left
        queue_cmd(MODE_LOAD,    10'd0,   32'd7);           // revive a spent bin
        queue_cmd(MODE_REQUEST, 10'h155, 32'd7);           // exact fit on bin 0
        queue_cmd(MODE_LOAD,    10'd512, 32'h8000_0000);
        queue_cmd(MODE_LOAD,    10'd513, 32'h7FFF_FFFF);
        queue_cmd(MODE_REQUEST, 10'd0,   32'h7FFF_FFFF);   // leftmost: 512
        queue_cmd(MODE_REQUEST, 10'd0,   32'h7FFF_FFFF);   // then 513
        queue_cmd(MODE_UNUSED,  10'h3FF, 32'hFFFF_FFFF);   // no-op mode
        queue_cmd(MODE_REQUEST, 10'h3FF, 32'd0);           // first unspent empty bin
        queue_cmd(MODE_LOAD,    10'h2AA, 32'hAAAA_AAAA);
        queue_cmd(MODE_LOAD,    10'h155, 32'h5555_5555);
        queue_cmd(MODE_REQUEST, 10'd0,   32'h5555_5555);
        queue_cmd(MODE_REQUEST, 10'd0,   32'h5555_5556);
        queue_cmd(MODE_CLEAR,   10'h3FF, 32'hFFFF_FFFF);   // clear with junk fields
        queue_cmd(MODE_REQUEST, 10'd0,   32'd0);           // count restarts at 1
        queue_cmd(MODE_REQUEST, 10'd0,   32'd1);           // no fit after clear

        // Random part: mostly loads and requests, demands often aimed at a
        // recently loaded capacity (exact, one below, one above); rare clears
        // and unused-mode noise.
        for (int k = 0; k < RANDOM_BEATS; k++) begin
            pick = $urandom_range(0, 999);
            kind = $urandom_range(0, 9);
            bin  = BIN_W'($urandom_range(0, 2**BIN_W - 1));
            if (pick < 15) begin
                queue_cmd(MODE_CLEAR, bin, $urandom, (k % DRAIN_EVERY) == 0);
            end else if (pick < 35) begin
                queue_cmd(MODE_UNUSED, bin, $urandom, (k % DRAIN_EVERY) == 0);
            end else if (pick < 500) begin
                if ($urandom_range(0, 3) == 0) begin
                    bin = BIN_W'($urandom_range(0, 31));   // churn the left edge
                end
                if (kind < 5) begin
                    amt = $urandom_range(0, 255);
                end else if (kind < 9) begin
                    amt = $urandom;
                end else begin
                    amt = '1 - $urandom_range(0, 2);
                end
                cap_memory.push_back(amt);
                if (cap_memory.size() > 16) begin
                    void'(cap_memory.pop_front());
                end
                queue_cmd(MODE_LOAD, bin, amt, (k % DRAIN_EVERY) == 0);
            end else begin
                if (kind == 0) begin
                    amt = '0;
                end else if (kind < 4 || cap_memory.size() == 0) begin
                    amt = $urandom_range(0, 255);
                end else if (kind < 7) begin
                    amt = cap_memory[$urandom_range(0, cap_memory.size() - 1)]
                          + $urandom_range(0, 2) - 1;
                end else if (kind < 9) begin
                    amt = $urandom;
                end else begin
                    amt = '1;
                end
                queue_cmd(MODE_REQUEST, bin, amt, (k % DRAIN_EVERY) == 0);
            end
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all beats sent and taken, all results back, then a quiet tail
        while (cmd_backlog.size() != 0 || req_ch.valid || predicted_rsps.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: roughly ten times the slowest expected run (power-up sweep,
    // a few dozen full clears, ~1550 beats with idles on both sides).
    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
